[rtl/irted_pkg.sv]
// Shared types and constants for the tagged response end detector.
package irted_pkg;

  // Character codes
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_OPEN  = 8'h7b;
  localparam logic [7:0] CH_CLOSE = 8'h7d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Widths fixed by the register map
  localparam int TAG_BYTES  = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int LEN_W      = 4;
  localparam int LINE_W     = 4;

  localparam logic [LINE_W-1:0] LINE_POS_MAX = LINE_W'(10);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAG_CHARS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_LENGTH = 1'b1;

  // Parser modes
  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_SIZE    = 6'b000010,
    MODE_WAIT_CR = 6'b000100,
    MODE_WAIT_LF = 6'b001000,
    MODE_DATA    = 6'b010000,
    MODE_GOT_TAG = 6'b100000
  } mode_t;

  // Classified byte handed from front to back
  typedef struct packed {
    logic                 is_cr;
    logic                 is_lf;
    logic                 is_open;
    logic                 is_close;
    logic                 is_digit;
    logic [3:0]           digit;
    logic [TAG_BYTES:0]   tag_hit;
    logic [LEN_W-1:0]     tag_len;
  } cls_t;

  // Result word
  typedef struct packed {
    logic response_done;
    logic in_literal;
    logic tag_seen;
  } res_t;

endpackage

[rtl/irted_fifo.sv]
// Two-entry register queue with full and empty flags.
module irted_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      if (do_wr && !do_rd) count <= count + 2'd1;
      else if (do_rd && !do_wr) count <= count - 2'd1;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

endmodule

[rtl/irted_front.sv]
// Front end: holds the tag registers and classifies each received byte.
module irted_front #(
  parameter int MAX_TAG = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [irted_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irted_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [7:0]                         data_byte,
  output irted_pkg::cls_t                    cls
);

  import irted_pkg::*;

  logic [CFG_DATA_W-1:0]       tag_chars;
  logic [LEN_W-1:0]            tag_length;
  logic [LEN_W-1:0]            eff_len;
  logic [8*(TAG_BYTES+1)-1:0]  prefix_ext;

  // Capture configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_chars  <= '0;
      tag_length <= LEN_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TAG_CHARS:  tag_chars  <= cfg_data;
        REG_TAG_LENGTH: tag_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp tag length into its legal range
  always_comb begin
    eff_len = tag_length;
    if (tag_length == '0) eff_len = LEN_W'(1);
    else if (tag_length > LEN_W'(MAX_TAG)) eff_len = LEN_W'(MAX_TAG);
  end

  assign prefix_ext = {CH_SPACE, tag_chars};

  // Classify the byte against delimiters, digits and every prefix position
  always_comb begin
    cls          = '0;
    cls.is_cr    = (data_byte == CH_CR);
    cls.is_lf    = (data_byte == CH_LF);
    cls.is_open  = (data_byte == CH_OPEN);
    cls.is_close = (data_byte == CH_CLOSE);
    cls.is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    cls.digit    = 4'(data_byte - CH_ZERO);
    cls.tag_len  = eff_len;
    for (int i = 0; i <= TAG_BYTES; i++) begin
      if (i <= MAX_TAG) begin
        if (LEN_W'(i) < eff_len) cls.tag_hit[i] = (data_byte == prefix_ext[8*i +: 8]);
        else cls.tag_hit[i] = (data_byte == CH_SPACE);
      end
    end
  end

endmodule

[rtl/irted_back.sv]
// Back end: parser state machine that turns classified bytes into result words.
module irted_back #(
  parameter int LITERAL_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  irted_pkg::cls_t  cls,
  output irted_pkg::res_t  res
);

  import irted_pkg::*;

  mode_t                   mode, mode_next;
  logic                    prev_cr, prev_cr_next;
  logic [LINE_W-1:0]       line_pos, line_pos_next;
  logic [LEN_W-1:0]        match_pos, match_pos_next;
  logic [LITERAL_BITS-1:0] size_acc, size_acc_next;
  logic [LITERAL_BITS-1:0] bytes_left, bytes_left_next;

  logic [LITERAL_BITS+3:0] size_wide;
  logic [LITERAL_BITS-1:0] left_dec;
  logic [LEN_W-1:0]        match_inc;
  logic                    pos_hit;

  // Size times ten plus the new digit, with headroom for saturation
  assign size_wide = ({4'b0, size_acc} << 3) + ({4'b0, size_acc} << 1)
                   + (LITERAL_BITS+4)'(cls.digit);
  assign left_dec  = bytes_left - LITERAL_BITS'(bytes_left != '0);
  assign match_inc = match_pos + LEN_W'(1);

  // Pick the prefix compare for the current match position
  always_comb begin
    pos_hit = 1'b0;
    for (int i = 0; i <= TAG_BYTES; i++) begin
      if (match_pos == LEN_W'(i) && cls.tag_hit[i]) pos_hit = 1'b1;
    end
  end

  // Next-state and result decode
  always_comb begin
    mode_next       = mode;
    prev_cr_next    = cls.is_cr;
    line_pos_next   = line_pos;
    match_pos_next  = match_pos;
    size_acc_next   = size_acc;
    bytes_left_next = bytes_left;
    res             = '0;
    unique case (mode)
      MODE_GOT_TAG: begin
        res.tag_seen = 1'b1;
        if (prev_cr && cls.is_lf) begin
          res.response_done = 1'b1;
          mode_next         = MODE_IDLE;
          prev_cr_next      = 1'b0;
          line_pos_next     = '0;
          match_pos_next    = '0;
          size_acc_next     = '0;
          bytes_left_next   = '0;
        end
      end
      MODE_IDLE: begin
        if (cls.is_open) begin
          mode_next      = MODE_SIZE;
          size_acc_next  = '0;
          res.in_literal = 1'b1;
        end else if (prev_cr && cls.is_lf) begin
          line_pos_next  = '0;
          match_pos_next = '0;
        end else begin
          if (match_pos == line_pos && match_pos <= cls.tag_len && pos_hit) begin
            match_pos_next = match_inc;
            if (match_inc == cls.tag_len + LEN_W'(1)) begin
              mode_next    = MODE_GOT_TAG;
              res.tag_seen = 1'b1;
            end
          end
          if (line_pos < LINE_POS_MAX) line_pos_next = line_pos + LINE_W'(1);
        end
      end
      MODE_SIZE: begin
        res.in_literal = 1'b1;
        if (cls.is_close) begin
          mode_next = MODE_WAIT_CR;
        end else if (cls.is_digit) begin
          if (size_wide[LITERAL_BITS+3:LITERAL_BITS] != 4'd0) size_acc_next = '1;
          else size_acc_next = size_wide[LITERAL_BITS-1:0];
        end
      end
      MODE_WAIT_CR: begin
        res.in_literal = 1'b1;
        if (cls.is_cr) begin
          mode_next = MODE_WAIT_LF;
        end else begin
          mode_next      = MODE_IDLE;
          match_pos_next = '0;
        end
      end
      MODE_WAIT_LF: begin
        res.in_literal = 1'b1;
        if (cls.is_lf && size_acc != '0) begin
          bytes_left_next = size_acc;
          mode_next       = MODE_DATA;
        end else begin
          if (cls.is_lf) bytes_left_next = size_acc;
          mode_next      = MODE_IDLE;
          match_pos_next = '0;
        end
      end
      MODE_DATA: begin
        res.in_literal  = 1'b1;
        bytes_left_next = left_dec;
        if (left_dec == '0) begin
          mode_next      = MODE_IDLE;
          match_pos_next = '0;
        end
      end
      default: begin
        mode_next      = MODE_IDLE;
        match_pos_next = '0;
      end
    endcase
  end

  // Advance parser state once per consumed word
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      prev_cr    <= 1'b0;
      line_pos   <= '0;
      match_pos  <= '0;
      size_acc   <= '0;
      bytes_left <= '0;
    end else if (step) begin
      mode       <= mode_next;
      prev_cr    <= prev_cr_next;
      line_pos   <= line_pos_next;
      match_pos  <= match_pos_next;
      size_acc   <= size_acc_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule

[rtl/imap_tagged_response_end_detector_unit.sv]
// Top level of the tagged response end detector: front, queues and parser.
// Takes one byte per clock while full is low and returns one result word per byte:
// response_done marks the LF that ends the line opened by the configured tag
// and a space at a line start, in_literal marks bytes consumed by a {N}
// literal header or its N data bytes, and tag_seen marks bytes from the
// completed tag match on. Sustained rate is one byte per cycle while neither
// queue stalls; a pushed word passes through the parser into the result queue.
// A two-entry queue sits between the classifier and the parser and
// another in front of the result ports, so either side may stall. Write
// tag_chars (index 0) and tag_length (index 1) only while no bytes are in
// flight; the literal size saturates at 2^LITERAL_BITS - 1.
module imap_tagged_response_end_detector_unit #(
  parameter int MAX_TAG      = 8,
  parameter int LITERAL_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [7:0]                        data_byte,
  output logic                              empty,
  input  logic                              pop,
  output logic                              response_done,
  output logic                              in_literal,
  output logic                              tag_seen,
  input  logic                              cfg_write,
  input  logic [irted_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [irted_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import irted_pkg::*;

  cls_t cls_in, cls_out;
  res_t res_in, res_out;
  logic mid_empty;
  logic res_full;
  logic step;

  // Classify incoming bytes
  irted_front #(
    .MAX_TAG (MAX_TAG)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .data_byte (data_byte),
    .cls       (cls_in)
  );

  // Queue classified words for the parser
  irted_fifo #(
    .WIDTH ($bits(cls_t))
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (cls_in),
    .full    (full),
    .rd_en   (step),
    .rd_data (cls_out),
    .empty   (mid_empty)
  );

  // Parse one word whenever one is waiting and the result queue has room
  assign step = !mid_empty && !res_full;

  irted_back #(
    .LITERAL_BITS (LITERAL_BITS)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cls  (cls_out),
    .res  (res_in)
  );

  // Hold result words until popped
  irted_fifo #(
    .WIDTH ($bits(res_t))
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (step),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign response_done = res_out.response_done;
  assign in_literal    = res_out.in_literal;
  assign tag_seen      = res_out.tag_seen;

endmodule
